[rtl/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg: shared types for the LSB steganography payload extractor
// Beat formats of the carrier, result and register write channels, result
// and error codes, and register indexes.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // Width of the header byte counter (the header is at most 63 bytes).
  localparam int unsigned HdrCntW  = 6;
  // Width of the register index on the write channel.
  localparam int unsigned CfgIdxW  = 4;
  // Width of the payload item counter (payload lengths stay below 2**31).
  localparam int unsigned ItemCntW = 31;

  typedef enum logic [2:0] {
    KIND_MAGIC_OK = 3'd0,
    KIND_EXT_LEN  = 3'd1,
    KIND_EXT_CHAR = 3'd2,
    KIND_PAY_LEN  = 3'd3,
    KIND_PAY_BYTE = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_MAGIC   = 2'd1,
    ERR_EXT_LEN = 2'd2,
    ERR_PAY_LEN = 2'd3
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC_CHARS  = 4'd0,
    CFG_MAGIC_LENGTH = 4'd1,
    CFG_MAX_EXT_LEN  = 4'd2,
    CFG_MAX_PAY_LEN  = 4'd3
  } cfg_idx_e;

  // One carrier byte beat.
  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       first;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    kind_e       out_kind;
    logic [31:0] out_value;
    err_e        error_code;
    logic        last;
  } out_beat_t;

  // One register write beat.
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [63:0]        wdata;
  } cfg_beat_t;

  // Register file contents handed to the decoder.
  typedef struct packed {
    logic [63:0] magic_chars;
    logic [3:0]  magic_length;
    logic [7:0]  max_extension_length;
    logic [30:0] max_payload_length;
  } cfg_regs_t;

endpackage

[rtl/lsp_stream_if.sv]
// ----------------------------------------------------------------------------
// lsp_stream_if: valid/ready channel
// Carries one payload beat from a source to a sink under valid and ready.
// ----------------------------------------------------------------------------
interface lsp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lsp_core.sv]
// ----------------------------------------------------------------------------
// lsp_core: decode state and per-byte next-state logic
// Updates the decode state on every accepted carrier byte and reports the
// result that byte produces, if any.
// ----------------------------------------------------------------------------
module lsp_core #(
  parameter int unsigned HEADER_BYTES = 54
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  lsp_pkg::in_beat_t  beat_i,
  input  lsp_pkg::cfg_regs_t cfg_i,
  output logic               res_valid_o,
  output lsp_pkg::out_beat_t res_o
);
  import lsp_pkg::*;

  typedef enum logic [6:0] {
    PH_HEADER    = 7'b0000001,
    PH_MAGIC     = 7'b0000010,
    PH_EXT_LEN   = 7'b0000100,
    PH_EXT_CHARS = 7'b0001000,
    PH_PAY_LEN   = 7'b0010000,
    PH_PAY_DATA  = 7'b0100000,
    PH_IDLE      = 7'b1000000
  } phase_e;

  localparam logic [HdrCntW-1:0] HdrLimit = HdrCntW'(HEADER_BYTES);

  phase_e                phase_q, phase_d;
  logic [HdrCntW-1:0]    hdr_cnt_q, hdr_cnt_d;
  logic [4:0]            bit_cnt_q, bit_cnt_d;
  logic [31:0]           shift_q, shift_d;
  logic [ItemCntW-1:0]   item_cnt_q, item_cnt_d;
  logic [7:0]            ext_len_q, ext_len_d;
  logic [30:0]           pay_len_q, pay_len_d;
  logic                  mismatch_q, mismatch_d;

  // Next state for one carrier byte. A byte marked first decodes from the
  // restart state rather than the stored one.
  always_comb begin
    phase_e              ph;
    logic [HdrCntW-1:0]  hdr;
    logic [4:0]          bcnt;
    logic [31:0]         sh;
    logic [ItemCntW-1:0] icnt;
    logic [ItemCntW-1:0] icnt_inc;
    logic                mis;
    logic                wide;
    logic [31:0]         shn;
    logic [31:0]         v;
    logic [3:0]          n;
    logic [2:0]          sel;
    logic [7:0]          expect_chr;

    if (beat_i.first) begin
      ph   = PH_HEADER;
      hdr  = '0;
      bcnt = '0;
      sh   = '0;
      icnt = '0;
      mis  = 1'b0;
    end else begin
      ph   = phase_q;
      hdr  = hdr_cnt_q;
      bcnt = bit_cnt_q;
      sh   = shift_q;
      icnt = item_cnt_q;
      mis  = mismatch_q;
    end

    phase_d    = ph;
    hdr_cnt_d  = hdr;
    bit_cnt_d  = bcnt;
    shift_d    = sh;
    item_cnt_d = icnt;
    mismatch_d = mis;
    ext_len_d  = beat_i.first ? 8'd0 : ext_len_q;
    pay_len_d  = beat_i.first ? 31'd0 : pay_len_q;

    res_valid_o      = 1'b0;
    res_o.out_kind   = KIND_MAGIC_OK;
    res_o.out_value  = '0;
    res_o.error_code = ERR_NONE;
    res_o.last       = 1'b0;

    icnt_inc   = icnt + ItemCntW'(1);
    wide       = (ph == PH_EXT_LEN) || (ph == PH_PAY_LEN);
    shn        = {sh[30:0], beat_i.carrier_byte[0]};
    v          = wide ? shn : {24'd0, shn[7:0]};

    // Clamp the magic length to one through eight characters.
    if (cfg_i.magic_length == 4'd0) begin
      n = 4'd1;
    end else if (cfg_i.magic_length > 4'd8) begin
      n = 4'd8;
    end else begin
      n = cfg_i.magic_length;
    end
    sel        = 3'(n - 4'd1 - icnt[3:0]);
    expect_chr = cfg_i.magic_chars[{sel, 3'b000} +: 8];

    // Header skip: count bytes, then fall through into the magic field.
    if (ph == PH_HEADER) begin
      if (hdr < HdrLimit) begin
        hdr_cnt_d = hdr + HdrCntW'(1);
      end else begin
        ph      = PH_MAGIC;
        phase_d = PH_MAGIC;
      end
    end

    if (ph != PH_HEADER && ph != PH_IDLE) begin
      if (bcnt != (wide ? 5'd31 : 5'd7)) begin
        // Gather one more bit of the current field.
        bit_cnt_d = bcnt + 5'd1;
        shift_d   = shn;
      end else begin
        bit_cnt_d = '0;
        shift_d   = '0;
        case (ph)
          PH_MAGIC: begin
            if (icnt < ItemCntW'(n) && expect_chr != v[7:0]) begin
              mis = 1'b1;
            end
            mismatch_d = mis;
            item_cnt_d = icnt_inc;
            if (icnt_inc >= ItemCntW'(n)) begin
              item_cnt_d  = '0;
              res_valid_o = 1'b1;
              if (mis) begin
                phase_d          = PH_IDLE;
                res_o.out_kind   = KIND_ERROR;
                res_o.error_code = ERR_MAGIC;
              end else begin
                phase_d        = PH_EXT_LEN;
                res_o.out_kind = KIND_MAGIC_OK;
              end
            end
          end
          PH_EXT_LEN: begin
            res_valid_o = 1'b1;
            if (v == 32'd0 || v > {24'd0, cfg_i.max_extension_length}) begin
              phase_d          = PH_IDLE;
              res_o.out_kind   = KIND_ERROR;
              res_o.error_code = ERR_EXT_LEN;
            end else begin
              ext_len_d       = v[7:0];
              item_cnt_d      = '0;
              phase_d         = PH_EXT_CHARS;
              res_o.out_kind  = KIND_EXT_LEN;
              res_o.out_value = v;
            end
          end
          PH_EXT_CHARS: begin
            res_valid_o     = 1'b1;
            res_o.out_kind  = KIND_EXT_CHAR;
            res_o.out_value = v;
            item_cnt_d      = icnt_inc;
            if (icnt_inc >= ItemCntW'(ext_len_q)) begin
              item_cnt_d = '0;
              phase_d    = PH_PAY_LEN;
            end
          end
          PH_PAY_LEN: begin
            res_valid_o = 1'b1;
            if (v == 32'd0 || v > {1'b0, cfg_i.max_payload_length}) begin
              phase_d          = PH_IDLE;
              res_o.out_kind   = KIND_ERROR;
              res_o.error_code = ERR_PAY_LEN;
            end else begin
              pay_len_d       = v[30:0];
              item_cnt_d      = '0;
              phase_d         = PH_PAY_DATA;
              res_o.out_kind  = KIND_PAY_LEN;
              res_o.out_value = v;
            end
          end
          default: begin
            // Payload data bytes.
            res_valid_o     = 1'b1;
            res_o.out_kind  = KIND_PAY_BYTE;
            res_o.out_value = v;
            item_cnt_d      = icnt_inc;
            if (icnt_inc >= pay_len_q) begin
              item_cnt_d = '0;
              phase_d    = PH_IDLE;
              res_o.last = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Decode state advances once per accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      item_cnt_q <= '0;
      ext_len_q  <= '0;
      pay_len_q  <= '0;
      mismatch_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      item_cnt_q <= item_cnt_d;
      ext_len_q  <= ext_len_d;
      pay_len_q  <= pay_len_d;
      mismatch_q <= mismatch_d;
    end
  end

endmodule

[rtl/lsb_stego_payload_extractor.sv]
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor: LSB steganography payload decoder
// Skips the image header, gathers the least significant bit of each carrier
// byte and emits the magic check, extension and payload fields.
//
//   Channel | Dir | Beat                                        | Accepted when
//   in_i    | in  | carrier_byte, first                         | valid & ready
//   out_o   | out | out_kind, out_value, error_code, last        | valid & ready
//   cfg_i   | in  | index, wdata                                | valid & ready
//
// One carrier byte is accepted per cycle; its result, if any, sits in the
// output register in the cycle after the byte is accepted. The single output
// register sets the figure: a new byte is taken whenever that register is
// empty or is being drained in the same cycle. A stall on the output holds
// the input off until the result beat is taken. Reset clears the decode
// state and loads the register defaults; the register port is always ready.
// ----------------------------------------------------------------------------
module lsb_stego_payload_extractor #(
  parameter int unsigned HEADER_BYTES = 54
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsp_stream_if.sink   in_i,
  lsp_stream_if.source out_o,
  lsp_stream_if.sink   cfg_i
);
  import lsp_pkg::*;

  cfg_regs_t cfg_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_data_q;
  logic      step;
  logic      res_valid;
  out_beat_t res;
  in_beat_t  in_beat;
  cfg_beat_t cfg_beat;

  assign in_beat  = in_i.data;
  assign cfg_beat = cfg_i.data;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_chars          <= 64'd8998;
      cfg_q.magic_length         <= 4'd2;
      cfg_q.max_extension_length <= 8'd4;
      cfg_q.max_payload_length   <= 31'd1048576;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_beat.index))
        CFG_MAGIC_CHARS:  cfg_q.magic_chars          <= cfg_beat.wdata;
        CFG_MAGIC_LENGTH: cfg_q.magic_length         <= cfg_beat.wdata[3:0];
        CFG_MAX_EXT_LEN:  cfg_q.max_extension_length <= cfg_beat.wdata[7:0];
        CFG_MAX_PAY_LEN:  cfg_q.max_payload_length   <= cfg_beat.wdata[30:0];
        default: ;
      endcase
    end
  end

  // Take a byte when the output register is free or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  lsp_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .beat_i     (in_beat),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

[rtl/lsp_checker.sv]
// ----------------------------------------------------------------------------
// lsp_checker: port-level checks for the payload extractor
// Watches the carrier and result channels and flags misbehavior.
// ----------------------------------------------------------------------------
module lsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_first_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input lsp_pkg::out_beat_t out_data_i
);
  import lsp_pkg::*;

  // A stalled result beat stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat dropped or changed while stalled");

  // No carrier byte is taken while a result waits on a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("carrier byte accepted over a stalled result");

  // A byte marked first never completes a field, so no result follows it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_first_i |=> !out_valid_i)
    else $error("result produced by a restarting byte");

  // Error kind and a nonzero error code always go together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.out_kind == KIND_ERROR) ==
                     (out_data_i.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // Only a payload byte can end the payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.last |-> out_data_i.out_kind == KIND_PAY_BYTE)
    else $error("last flag on a result that is not a payload byte");

endmodule

bind lsb_stego_payload_extractor lsp_checker u_lsp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_first_i (in_i.data.first),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
